/* sv/assert_macros.svh */
// Assertion macros shared by the deadline queue modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define MTDQ_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("deadline queue assertion failed");
`define MTDQ_NEVER(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error("deadline queue forbidden condition");
`else
`define MTDQ_ASSERT(lbl, prop)
`define MTDQ_NEVER(lbl, cond)
`endif
`endif

/* sv/mtdq_pkg.sv */
// Shared constants and control types of the deadline queue.
`timescale 1ns / 1ps
package mtdq_pkg;
    localparam int SLOTS     = 16;
    localparam int IDX_W     = $clog2(SLOTS);
    localparam int MAX_FIRES = 16;
    localparam int CNT_W     = 5;
    localparam int TIME_W    = 63;
    localparam int PER_W     = 40;
    localparam int ID_W      = 32;
    localparam int IN_W      = 144;
    localparam int OUT_W     = 104;

    localparam logic [1:0] OP_ONESHOT  = 2'd0;
    localparam logic [1:0] OP_PERIODIC = 2'd1;
    localparam logic [1:0] OP_CANCEL   = 2'd2;
    localparam logic [1:0] OP_DRAIN    = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;

    typedef struct packed {
        logic             load;
        logic             sched;
        logic             cancel_step;
        logic             pick_step;
        logic             fire;
        logic             div_step;
        logic             upd;
        logic             min_step;
        logic             emit_load;
        logic             emit_last;
        logic [IDX_W-1:0] idx;
        logic [CNT_W-1:0] eidx;
    } t_cmd;

    typedef struct packed {
        logic             cancel_hit;
        logic             pick_found;
        logic             pick_per_zero;
        logic [CNT_W-1:0] fire_cnt;
        logic             out_free;
        logic [1:0]       op;
    } t_sts;
endpackage

/* sv/mtdq_ctrl.sv */
// Sequencer of the deadline queue: scans, catch-up division and result emission.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mtdq_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    input  logic [1:0]     i_req_op,
    output logic           o_req_ready,
    input  mtdq_pkg::t_sts i_sts,
    output mtdq_pkg::t_cmd o_cmd
);
    import mtdq_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCHED  = 3'd1;
    localparam logic [2:0] S_CANCEL = 3'd2;
    localparam logic [2:0] S_PICK   = 3'd3;
    localparam logic [2:0] S_FIRE   = 3'd4;
    localparam logic [2:0] S_DIV    = 3'd5;
    localparam logic [2:0] S_UPD    = 3'd6;
    localparam logic [2:0] S_MIN    = 3'd7;
    localparam logic [2:0] S_EMIT   = 3'd0;

    logic [2:0]       r_state, n_state;
    logic             r_emit, n_emit;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [5:0]       r_bit, n_bit;
    logic [CNT_W-1:0] r_eidx, n_eidx;
    logic             idx_last;
    logic [CNT_W-1:0] total;

    assign idx_last = (r_idx == IDX_W'(SLOTS - 1));
    assign total = (i_sts.op == OP_DRAIN && i_sts.fire_cnt != '0) ? i_sts.fire_cnt
                                                                   : CNT_W'(1);
    assign o_req_ready = (r_state == S_IDLE) && !r_emit;

    always_comb begin
        n_state = r_state;
        n_emit  = r_emit;
        n_idx   = r_idx;
        n_bit   = r_bit;
        n_eidx  = r_eidx;
        o_cmd   = '0;
        o_cmd.idx  = r_idx;
        o_cmd.eidx = r_eidx;
        o_cmd.emit_last = (r_eidx == total - CNT_W'(1));
        if (r_emit) begin
            // Results leave only after the whole step, so each carries the final minimum.
            if (i_sts.out_free) begin
                o_cmd.emit_load = 1'b1;
                if (o_cmd.emit_last) begin
                    n_emit = 1'b0;
                end else begin
                    n_eidx = r_eidx + CNT_W'(1);
                end
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_req_valid) begin
                        o_cmd.load = 1'b1;
                        n_idx = '0;
                        case (i_req_op)
                            OP_ONESHOT, OP_PERIODIC: n_state = S_SCHED;
                            OP_CANCEL:               n_state = S_CANCEL;
                            default:                 n_state = S_PICK;
                        endcase
                    end
                end
                S_SCHED: begin
                    o_cmd.sched = 1'b1;
                    n_state = S_MIN;
                end
                S_CANCEL: begin
                    o_cmd.cancel_step = 1'b1;
                    n_idx = r_idx + IDX_W'(1);
                    if (i_sts.cancel_hit || idx_last) begin
                        n_idx = '0;
                        n_state = S_MIN;
                    end
                end
                S_PICK: begin
                    o_cmd.pick_step = 1'b1;
                    n_idx = r_idx + IDX_W'(1);
                    if (idx_last) begin
                        n_idx = '0;
                        n_state = S_FIRE;
                    end
                end
                S_FIRE: begin
                    if (!i_sts.pick_found) begin
                        n_state = S_MIN;
                    end else begin
                        o_cmd.fire = 1'b1;
                        if (!i_sts.pick_per_zero) begin
                            n_bit = 6'(TIME_W - 1);
                            n_state = S_DIV;
                        end else if (i_sts.fire_cnt == CNT_W'(MAX_FIRES - 1)) begin
                            n_state = S_MIN;
                        end else begin
                            n_state = S_PICK;
                        end
                    end
                end
                S_DIV: begin
                    o_cmd.div_step = 1'b1;
                    n_bit = r_bit - 6'd1;
                    if (r_bit == '0) begin
                        n_state = S_UPD;
                    end
                end
                S_UPD: begin
                    o_cmd.upd = 1'b1;
                    n_state = (i_sts.fire_cnt == CNT_W'(MAX_FIRES)) ? S_MIN : S_PICK;
                end
                S_MIN: begin
                    o_cmd.min_step = 1'b1;
                    n_idx = r_idx + IDX_W'(1);
                    if (idx_last) begin
                        n_idx = '0;
                        n_eidx = '0;
                        n_emit = 1'b1;
                        n_state = S_EMIT;
                    end
                end
                default: n_state = S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_emit  <= 1'b0;
            r_idx   <= '0;
            r_bit   <= '0;
            r_eidx  <= '0;
        end else begin
            r_state <= n_state;
            r_emit  <= n_emit;
            r_idx   <= n_idx;
            r_bit   <= n_bit;
            r_eidx  <= n_eidx;
        end
    end

    `MTDQ_NEVER(a_emit_busy, r_emit && r_state != S_IDLE)
    `MTDQ_ASSERT(a_fire_found, o_cmd.fire |-> i_sts.pick_found)
    `MTDQ_ASSERT(a_load_idle, o_cmd.load |=> !o_req_ready)
endmodule

/* sv/mtdq_dp.sv */
// Timer table, scan trackers, catch-up remainder unit and result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mtdq_dp (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [mtdq_pkg::IN_W-1:0] i_req_data,
    input  mtdq_pkg::t_cmd            i_cmd,
    output mtdq_pkg::t_sts            o_sts,
    input  logic                      i_res_ready,
    output logic                      o_res_valid,
    output logic [mtdq_pkg::OUT_W-1:0] o_res_data,
    output logic                      o_res_last
);
    import mtdq_pkg::*;

    logic [SLOTS-1:0]  r_valid;
    logic [ID_W-1:0]   r_id  [SLOTS];
    logic [TIME_W-1:0] r_dl  [SLOTS];
    logic [PER_W-1:0]  r_per [SLOTS];
    logic [ID_W-1:0]   r_ctr;
    logic [ID_W-1:0]   r_buf [MAX_FIRES];

    logic [1:0]        r_op;
    logic [TIME_W-1:0] r_now;
    logic [PER_W-1:0]  r_dp;
    logic [ID_W-1:0]   r_tid;
    logic              r_hit;
    logic [1:0]        r_sst;
    logic [ID_W-1:0]   r_sid;
    logic [CNT_W-1:0]  r_cnt;

    logic              r_pfound;
    logic [IDX_W-1:0]  r_pslot;
    logic [TIME_W-1:0] r_pdl;
    logic [PER_W-1:0]  r_pper;
    logic [ID_W-1:0]   r_pid;
    logic [TIME_W-1:0] r_dvd;
    logic [PER_W-1:0]  r_rem;
    logic              r_mfound;
    logic [TIME_W-1:0] r_mdl;

    logic              r_ovalid;
    logic [OUT_W-1:0]  r_odata;
    logic              r_olast;

    logic [IDX_W-1:0]  free_slot;
    logic              free_any;
    logic [TIME_W:0]   sum;
    logic              due, hit;
    logic [PER_W:0]    trial;
    logic [TIME_W:0]   nd;
    logic [1:0]        o_st;
    logic [ID_W-1:0]   o_id;
    logic              o_fired;
    logic [CNT_W-1:0]  o_cnt;

    always_comb begin
        free_slot = '0;
        free_any  = 1'b0;
        for (int s = SLOTS - 1; s >= 0; s--) begin
            if (!r_valid[s]) begin
                free_slot = IDX_W'(s);
                free_any  = 1'b1;
            end
        end
    end

    assign sum   = {1'b0, r_now} + {{(TIME_W - PER_W + 1){1'b0}}, r_dp};
    assign due   = r_valid[i_cmd.idx] && (r_dl[i_cmd.idx] <= r_now);
    assign hit   = r_valid[i_cmd.idx] && (r_id[i_cmd.idx] == r_tid);
    assign trial = {r_rem, r_dvd[TIME_W-1]};
    // Next deadline is now minus (now - deadline) mod period, plus one period.
    assign nd    = {1'b0, r_now} - {{(TIME_W - PER_W + 1){1'b0}}, r_rem}
                 + {{(TIME_W - PER_W + 1){1'b0}}, r_pper};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_ctr   <= '0;
            r_cnt   <= '0;
            r_hit   <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_cnt <= '0;
                r_hit <= 1'b0;
            end
            if (i_cmd.sched && free_any) begin
                r_valid[free_slot] <= 1'b1;
                r_ctr <= r_ctr + ID_W'(1);
            end
            if (i_cmd.cancel_step && hit) begin
                r_valid[i_cmd.idx] <= 1'b0;
                r_hit <= 1'b1;
            end
            if (i_cmd.fire) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_pper == '0) begin
                    r_valid[r_pslot] <= 1'b0;
                end
            end
            if (i_cmd.upd && nd[TIME_W]) begin
                r_valid[r_pslot] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_req_data[1:0];
            r_now <= i_req_data[TIME_W+1:2];
            r_dp  <= i_req_data[TIME_W+PER_W+1:TIME_W+2];
            r_tid <= i_req_data[TIME_W+PER_W+ID_W+1:TIME_W+PER_W+2];
        end
        if (i_cmd.sched) begin
            r_sst <= free_any ? ST_OK : ST_FULL;
            r_sid <= free_any ? r_ctr : '0;
            if (free_any) begin
                r_id[free_slot]  <= r_ctr;
                r_dl[free_slot]  <= sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
                r_per[free_slot] <= (r_op == OP_PERIODIC) ? r_dp : '0;
            end
        end
        if (i_cmd.pick_step) begin
            if (i_cmd.idx == '0 || !r_pfound) begin
                r_pfound <= due;
            end
            if (due && (i_cmd.idx == '0 || !r_pfound || r_dl[i_cmd.idx] < r_pdl)) begin
                r_pslot <= i_cmd.idx;
                r_pdl   <= r_dl[i_cmd.idx];
                r_pper  <= r_per[i_cmd.idx];
                r_pid   <= r_id[i_cmd.idx];
            end
        end
        if (i_cmd.fire) begin
            r_buf[r_cnt[IDX_W-1:0]] <= r_pid;
            r_dvd <= r_now - r_pdl;
            r_rem <= '0;
        end
        if (i_cmd.div_step) begin
            r_dvd <= {r_dvd[TIME_W-2:0], 1'b0};
            r_rem <= (trial >= {1'b0, r_pper}) ? PER_W'(trial - {1'b0, r_pper})
                                               : trial[PER_W-1:0];
        end
        if (i_cmd.upd && !nd[TIME_W]) begin
            r_dl[r_pslot] <= nd[TIME_W-1:0];
        end
        if (i_cmd.min_step) begin
            if (i_cmd.idx == '0 || !r_mfound) begin
                r_mfound <= r_valid[i_cmd.idx];
            end
            if (r_valid[i_cmd.idx] &&
                (i_cmd.idx == '0 || !r_mfound || r_dl[i_cmd.idx] < r_mdl)) begin
                r_mdl <= r_dl[i_cmd.idx];
            end
        end
    end

    always_comb begin
        o_st    = ST_OK;
        o_id    = '0;
        o_fired = 1'b0;
        o_cnt   = '0;
        case (r_op)
            OP_ONESHOT, OP_PERIODIC: begin
                o_st = r_sst;
                o_id = r_sid;
            end
            OP_CANCEL: begin
                o_st = r_hit ? ST_OK : ST_NOTFOUND;
                o_id = r_tid;
            end
            default: begin
                if (r_cnt != '0) begin
                    o_id    = r_buf[i_cmd.eidx[IDX_W-1:0]];
                    o_fired = 1'b1;
                    o_cnt   = i_cmd.eidx + CNT_W'(1);
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit_load) begin
            r_ovalid <= 1'b1;
        end else if (i_res_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_load) begin
            r_odata <= {r_mfound, (r_mfound ? r_mdl : {TIME_W{1'b0}}),
                        o_cnt, o_fired, o_id, o_st};
            r_olast <= i_cmd.emit_last;
        end
    end

    assign o_res_valid = r_ovalid;
    assign o_res_data  = r_odata;
    assign o_res_last  = r_olast;

    assign o_sts.cancel_hit    = hit;
    assign o_sts.pick_found    = r_pfound;
    assign o_sts.pick_per_zero = (r_pper == '0);
    assign o_sts.fire_cnt      = r_cnt;
    assign o_sts.out_free      = !r_ovalid || i_res_ready;
    assign o_sts.op            = r_op;

    `MTDQ_NEVER(a_cnt_range, r_cnt > CNT_W'(MAX_FIRES))
    `MTDQ_ASSERT(a_rem_range, i_cmd.upd |-> (r_rem < r_pper))
    `MTDQ_NEVER(a_emit_over, i_cmd.emit_load && r_ovalid && !i_res_ready)
endmodule

/* sv/multi_timer_deadline_queue.sv */
// Top level of the timer deadline queue: sequencer plus timer table datapath.
//
//  channel   | direction | tdata bits                                   | tlast
//  s_axis    | in        | opcode, now_time, delay_or_period, target_id | -
//  m_axis    | out       | status, timer_id, fired, fired_count,        | last
//            |           | next_deadline, next_valid                    |
//
// Schedule writes a free slot; cancel scans slots up to the hit; both then scan for the minimum.
// Drain repeats a pick pass over all slots, with a bit-serial remainder step
// for each periodic timer fired, then scans all slots for the minimum.
// Results are buffered and sent after the whole step; a stalled m_axis holds the rest.
// Reset is synchronous and active low; it empties the table and zeroes the id counter.
`timescale 1ns / 1ps
module multi_timer_deadline_queue (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // opcode[1:0], now_time[64:2], delay_or_period[104:65], target_id[136:105]
    input  logic [143:0] i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // status[1:0], timer_id[33:2], fired[34], fired_count[39:35],
    // next_deadline[102:40], next_valid[103]
    output logic [103:0] o_m_axis_tdata,
    output logic         o_m_axis_tlast
);
    import mtdq_pkg::*;

    t_cmd cmd;
    t_sts sts;

    mtdq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_s_axis_tvalid),
        .i_req_op    (i_s_axis_tdata[1:0]),
        .o_req_ready (o_s_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    mtdq_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_data  (i_s_axis_tdata),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_res_ready (i_m_axis_tready),
        .o_res_valid (o_m_axis_tvalid),
        .o_res_data  (o_m_axis_tdata),
        .o_res_last  (o_m_axis_tlast)
    );
endmodule

/* sim/tb_multi_timer_deadline_queue.sv */
// Self-checking testbench for the timer deadline queue: random stimulus, stalls, table predictor.
`timescale 1ns / 1ps
module tb_multi_timer_deadline_queue;
    import mtdq_pkg::*;

    localparam logic [62:0] TIME_MAX = {63{1'b1}};

    typedef struct packed {
        logic [31:0] target_id;
        logic [39:0] delay;
        logic [62:0] now_time;
        logic [1:0]  opcode;
    } t_request;

    // Laid out as {tdata, tlast}: the first tdata field sits just above last.
    typedef struct packed {
        logic        next_valid;
        logic [62:0] next_deadline;
        logic [4:0]  fired_count;
        logic        fired;
        logic [31:0] timer_id;
        logic [1:0]  status;
        logic        last;
    } t_result;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_axis_tvalid = 1'b0;
    logic         o_s_axis_tready;
    logic [143:0] i_s_axis_tdata = '0;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b0;
    logic [103:0] o_m_axis_tdata;
    logic         o_m_axis_tlast;

    multi_timer_deadline_queue dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predicted state of the timer table.
    logic        tbl_valid[SLOTS];
    logic [31:0] tbl_id[SLOTS];
    logic [62:0] tbl_deadline[SLOTS];
    logic [39:0] tbl_period[SLOTS];
    logic [31:0] next_id;

    t_request pending_q[$];
    t_result  expected_q[$];
    int       errors = 0;
    int       results_seen = 0;
    int       fires_seen = 0;
    bit       hold_sink = 0;

    function automatic void predict_request(t_request rq);
        t_result r[$];
        t_result one;
        int free_slot, pick, n;
        logic [1:0] st;
        logic [63:0] sum, nd, steps;
        logic [62:0] best;
        logic any;
        one = '0;
        if (rq.opcode == OP_ONESHOT || rq.opcode == OP_PERIODIC) begin
            free_slot = -1;
            for (int s = SLOTS - 1; s >= 0; s--) if (!tbl_valid[s]) free_slot = s;
            one.last = 1'b1;
            if (free_slot < 0) begin
                one.status = ST_FULL;
            end else begin
                sum = {1'b0, rq.now_time} + {24'd0, rq.delay};
                tbl_valid[free_slot] = 1'b1;
                tbl_id[free_slot] = next_id;
                tbl_deadline[free_slot] = sum[63] ? TIME_MAX : sum[62:0];
                tbl_period[free_slot] = (rq.opcode == OP_PERIODIC) ? rq.delay : '0;
                one.status = ST_OK;
                one.timer_id = next_id;
                next_id++;
            end
            r.push_back(one);
        end else if (rq.opcode == OP_CANCEL) begin
            st = ST_NOTFOUND;
            for (int s = 0; s < SLOTS; s++) begin
                if (st == ST_NOTFOUND && tbl_valid[s] && tbl_id[s] == rq.target_id) begin
                    tbl_valid[s] = 1'b0;
                    st = ST_OK;
                end
            end
            one.status = st;
            one.timer_id = rq.target_id;
            one.last = 1'b1;
            r.push_back(one);
        end else begin
            n = 0;
            while (n < MAX_FIRES) begin
                pick = -1;
                for (int s = 0; s < SLOTS; s++)
                    if (tbl_valid[s] && tbl_deadline[s] <= rq.now_time &&
                        (pick < 0 || tbl_deadline[s] < tbl_deadline[pick]))
                        pick = s;
                if (pick < 0) break;
                one = '0;
                one.timer_id = tbl_id[pick];
                one.fired = 1'b1;
                n++;
                one.fired_count = n[4:0];
                r.push_back(one);
                if (tbl_period[pick] == '0) begin
                    tbl_valid[pick] = 1'b0;
                end else begin
                    steps = (rq.now_time - tbl_deadline[pick]) / tbl_period[pick] + 1;
                    nd = tbl_deadline[pick] + steps * tbl_period[pick];
                    if (nd > {1'b0, TIME_MAX}) tbl_valid[pick] = 1'b0;
                    else tbl_deadline[pick] = nd[62:0];
                end
            end
            if (n == 0) begin
                one = '0;
                r.push_back(one);
            end
            r[r.size() - 1].last = 1'b1;
        end
        best = '0;
        any = 1'b0;
        for (int s = 0; s < SLOTS; s++)
            if (tbl_valid[s] && (!any || tbl_deadline[s] < best)) begin
                best = tbl_deadline[s];
                any = 1'b1;
            end
        foreach (r[k]) begin
            r[k].next_deadline = best;
            r[k].next_valid = any;
            expected_q.push_back(r[k]);
        end
    endfunction

    function automatic int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    endfunction

    // Driver: offers queued requests with random gaps.
    int src_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                predict_request(t_request'(i_s_axis_tdata[136:0]));
                src_gap = gap_len();
                if (src_gap == 0 && pending_q.size() > 0) begin
                    i_s_axis_tdata <= {7'd0, pending_q.pop_front()};
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end else if (!i_s_axis_tvalid) begin
                if (src_gap > 0) src_gap--;
                else if (pending_q.size() > 0) begin
                    i_s_axis_tdata <= {7'd0, pending_q.pop_front()};
                    i_s_axis_tvalid <= 1'b1;
                end
            end
        end
    end

    // Monitor: checks results and throttles the master side.
    int sink_gap = 0;
    always @(posedge i_clk) begin
        t_result got, exp_r;
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got = {o_m_axis_tdata, o_m_axis_tlast};
                results_seen++;
                if (got.fired) fires_seen++;
                if (expected_q.size() == 0) begin
                    $error("unexpected result %h", got);
                    errors++;
                end else begin
                    exp_r = expected_q.pop_front();
                    if (got.status != exp_r.status) begin
                        $error("status exp %0d got %0d", exp_r.status, got.status); errors++;
                    end
                    if (got.timer_id != exp_r.timer_id) begin
                        $error("timer_id exp %0d got %0d", exp_r.timer_id, got.timer_id);
                        errors++;
                    end
                    if (got.fired != exp_r.fired) begin
                        $error("fired exp %0d got %0d", exp_r.fired, got.fired); errors++;
                    end
                    if (got.fired_count != exp_r.fired_count) begin
                        $error("fired_count exp %0d got %0d", exp_r.fired_count,
                               got.fired_count);
                        errors++;
                    end
                    if (got.next_deadline != exp_r.next_deadline) begin
                        $error("next_deadline exp %0d got %0d", exp_r.next_deadline,
                               got.next_deadline);
                        errors++;
                    end
                    if (got.next_valid != exp_r.next_valid) begin
                        $error("next_valid exp %0d got %0d", exp_r.next_valid, got.next_valid);
                        errors++;
                    end
                    if (got.last != exp_r.last) begin
                        $error("last exp %0d got %0d", exp_r.last, got.last); errors++;
                    end
                end
            end
            if (hold_sink) begin
                i_m_axis_tready <= 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap--;
                i_m_axis_tready <= 1'b0;
            end else begin
                sink_gap = gap_len();
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    // Long receiver hold-off so the output buffer fills and the input stalls.
    initial begin
        int held;
        held = 0;
        wait (i_rst_n);
        repeat (3000) @(posedge i_clk);
        hold_sink = 1;
        while (held < 4000) begin
            @(posedge i_clk);
            held++;
        end
        hold_sink = 0;
    end

    function automatic t_request mk(logic [1:0] op, logic [62:0] t, logic [39:0] d,
                                    logic [31:0] id);
        t_request rq;
        rq.opcode = op;
        rq.now_time = t;
        rq.delay = d;
        rq.target_id = id;
        return rq;
    endfunction

    function automatic logic [62:0] rand63();
        return 63'({$urandom(), $urandom()});
    endfunction

    initial begin
        logic [62:0] clock_now;
        logic [1:0] op;
        logic [31:0] sched_n;
        int pick;
        for (int s = 0; s < SLOTS; s++) tbl_valid[s] = 1'b0;
        next_id = '0;
        // Directed: empty drain, saturating deadline, zero period, full table, cancels.
        pending_q.push_back(mk(OP_DRAIN, 63'd0, 40'd0, 32'd0));
        pending_q.push_back(mk(OP_CANCEL, 63'd0, 40'd0, 32'hFFFF_FFFF));
        pending_q.push_back(mk(OP_ONESHOT, TIME_MAX, {40{1'b1}}, 32'd0));
        pending_q.push_back(mk(OP_PERIODIC, 63'd100, 40'd0, 32'd0));
        pending_q.push_back(mk(OP_PERIODIC, TIME_MAX - 63'd5, 40'd4, 32'd0));
        for (int k = 0; k < 14; k++)
            pending_q.push_back(mk(k[0] ? OP_PERIODIC : OP_ONESHOT, 63'd50, 40'd10 + k % 3,
                                   32'd0));
        pending_q.push_back(mk(OP_CANCEL, 63'd0, 40'd0, 32'd1));
        pending_q.push_back(mk(OP_CANCEL, 63'd0, 40'd0, 32'd1));
        pending_q.push_back(mk(OP_DRAIN, 63'd1000, 40'd0, 32'd0));
        pending_q.push_back(mk(OP_DRAIN, TIME_MAX, 40'd0, 32'd0));
        pending_q.push_back(mk(OP_DRAIN, TIME_MAX, 40'd0, 32'd0));
        pending_q.push_back(mk(OP_DRAIN, TIME_MAX, 40'd0, 32'd0));
        sched_n = 32'd17;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // Random: mostly monotonic time with short delays, some far-out values.
        clock_now = 63'd0;
        for (int k = 0; k < 320; k++) begin
            pick = $urandom_range(0, 99);
            clock_now = clock_now + $urandom_range(0, 200);
            op = (pick < 30) ? OP_ONESHOT : (pick < 55) ? OP_PERIODIC :
                 (pick < 70) ? OP_CANCEL : OP_DRAIN;
            if ($urandom_range(0, 19) == 0)
                pending_q.push_back(mk(op, rand63(), {$urandom(), 8'($urandom())},
                                       $urandom()));
            else
                pending_q.push_back(mk(op, clock_now, 40'($urandom_range(0, 600)),
                                       sched_n - $urandom_range(1, 20)));
            if (op == OP_ONESHOT || op == OP_PERIODIC) sched_n++;
        end
        wait (pending_q.size() == 0 && !i_s_axis_tvalid && expected_q.size() == 0);
        repeat (2000) @(posedge i_clk);
        $display("Covered %0d results, %0d of them fired timers, under random stalls.",
                 results_seen, fires_seen);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #50ms;
        $display("end of test: mismatches");
        $finish;
    end
endmodule

/* multi_timer_deadline_queue.f */
+incdir+sv
sv/mtdq_pkg.sv
sv/mtdq_ctrl.sv
sv/mtdq_dp.sv
sv/multi_timer_deadline_queue.sv
sim/tb_multi_timer_deadline_queue.sv
